FILE: src/spa_pkg.sv
`default_nettype none
package spa_pkg;

	localparam int FIELD_W    = 13;
	localparam int STATUS_W   = 2;
	localparam int PAGE_NUM_W = 4;
	localparam int LIMIT_W    = 5;
	localparam int CFG_W      = 13;

	localparam logic [FIELD_W-1:0] PAGE_SIZE_RST  = 13'd512;
	localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 5'd16;

	typedef enum logic [0:0] {
		MODE_ALLOC = 1'b0,
		MODE_CLEAR = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_SIZE = 2'd1,
		STAT_NO_ROOM  = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_PAGE_SIZE  = 1'b0,
		REG_PAGE_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_OPEN
	} state_t;

	// what the datapath does when a result is committed
	typedef enum logic [2:0] {
		RES_CLEAR,
		RES_BAD,
		RES_FIT,
		RES_SHELF,
		RES_NOROOM,
		RES_OPEN
	} res_kind_t;

	typedef struct packed {
		logic      load_in;
		logic      step;
		logic      load_res;
		res_kind_t kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic bad_size;
		logic none_open;
		logic fit;
		logic new_shelf;
		logic more;
		logic full;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: src/spa_ctrl.sv
`default_nettype none
module spa_ctrl import spa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire dp_status_t st,
	output ctrl_cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_res)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.load_in  = 1'b0;
		cmd.step     = 1'b0;
		cmd.load_res = 1'b0;
		cmd.kind     = RES_CLEAR;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (st.is_clear || st.bad_size) begin
					cmd.kind = st.is_clear ? RES_CLEAR : RES_BAD;
					if (out_free) begin
						cmd.load_res = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (st.none_open) begin
					state_d = S_OPEN;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				priority if (st.fit || st.new_shelf) begin
					cmd.kind = st.fit ? RES_FIT : RES_SHELF;
					if (out_free) begin
						cmd.load_res = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (st.more) begin
					cmd.step = 1'b1;
				end else begin
					state_d = S_OPEN;
				end
			end
			S_OPEN: begin
				cmd.kind = st.full ? RES_NOROOM : RES_OPEN;
				if (out_free) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> (!out_valid_q || !out_stall))
		else $error("result committed over an untaken result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |=> out_valid_q)
		else $error("committed result not presented");

	a_step_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (state_q == S_WALK && st.more && !st.fit && !st.new_shelf))
		else $error("page walk advanced outside a miss");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_valid) |=> state_q == S_IDLE)
		else $error("left idle without a transfer");
`endif

endmodule
`default_nettype wire

FILE: src/spa_datapath.sv
`default_nettype none
module spa_datapath import spa_pkg::*; #(
	parameter int MAX_PAGES  = 16,
	parameter int COORD_BITS = 13
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [0:0]            cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  mode,
	input  wire logic [FIELD_W-1:0]    cell_width,
	input  wire logic [FIELD_W-1:0]    cell_height,
	input  wire ctrl_cmd_t             cmd,
	output dp_status_t                 st,
	output logic [STATUS_W-1:0]        status,
	output logic [PAGE_NUM_W-1:0]      page_number,
	output logic [FIELD_W-1:0]         left,
	output logic [FIELD_W-1:0]         top,
	output logic [FIELD_W-1:0]         right,
	output logic [FIELD_W-1:0]         bottom
);

	localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PW = $clog2(MAX_PAGES + 1);
	localparam int AW = ((COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W) + 2;

	logic [FIELD_W-1:0]    page_size_q;
	logic [LIMIT_W-1:0]    page_limit_q;
	logic                  mode_q;
	logic [FIELD_W-1:0]    w_q, h_q;
	logic [IW-1:0]         idx_q;
	logic [PW-1:0]         pages_open_q;

	// shelf store, one entry per page
	logic [COORD_BITS-1:0] mem_x [MAX_PAGES];
	logic [COORD_BITS-1:0] mem_y [MAX_PAGES];
	logic [COORD_BITS-1:0] mem_h [MAX_PAGES];
	logic [COORD_BITS-1:0] rd_x_q, rd_y_q, rd_h_q;

	logic [IW:0]           idx_inc;
	logic [IW-1:0]         rd_addr;
	logic [AW-1:0]         x_e, y_e, hs_e, w_e, h_e, ps_e;
	logic [AW-1:0]         sum_xw, ny, sum_nyh;

	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [COORD_BITS-1:0] wr_x, wr_y, wr_h;
	status_t               res_status;
	logic [PAGE_NUM_W-1:0] res_page;
	logic [FIELD_W-1:0]    res_l, res_t, res_r, res_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q  <= PAGE_SIZE_RST;
			page_limit_q <= PAGE_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAGE_SIZE:  page_size_q  <= cfg_data[FIELD_W-1:0];
				REG_PAGE_LIMIT: page_limit_q <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_open_q <= '0;
		end else if (cmd.load_res) begin
			if (cmd.kind == RES_CLEAR)
				pages_open_q <= '0;
			else if (cmd.kind == RES_OPEN)
				pages_open_q <= pages_open_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= mode;
			w_q    <= cell_width;
			h_q    <= cell_height;
			idx_q  <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_inc[IW-1:0];
		end
	end

	// walk read port, read data registered from the address
	always_ff @(posedge clk) begin
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
		rd_h_q <= mem_h[rd_addr];
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
			mem_h[wr_addr] <= wr_h;
		end
	end

	assign idx_inc = {1'b0, idx_q} + (IW+1)'(1);
	assign rd_addr = cmd.step ? idx_inc[IW-1:0] : idx_q;

	assign x_e  = AW'(rd_x_q);
	assign y_e  = AW'(rd_y_q);
	assign hs_e = AW'(rd_h_q);
	assign w_e  = AW'(w_q);
	assign h_e  = AW'(h_q);
	assign ps_e = AW'(page_size_q);

	assign sum_xw  = x_e + w_e;
	assign ny      = y_e + hs_e;
	assign sum_nyh = ny + h_e;

	assign st.is_clear  = (mode_t'(mode_q) == MODE_CLEAR);
	assign st.bad_size  = (w_q == '0) || (h_q == '0) || (w_q > page_size_q)
	                      || (h_q > page_size_q);
	assign st.none_open = (pages_open_q == '0);
	assign st.fit       = (sum_xw <= ps_e) && (h_e <= hs_e);
	assign st.new_shelf = (rd_h_q != '0) && (sum_nyh <= ps_e);
	assign st.more      = (8'(idx_inc) < 8'(pages_open_q));
	assign st.full      = (8'(pages_open_q) >= 8'(page_limit_q))
	                      || (pages_open_q >= PW'(MAX_PAGES));

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = idx_q;
		wr_x       = rd_x_q;
		wr_y       = rd_y_q;
		wr_h       = rd_h_q;
		res_status = STAT_OK;
		res_page   = '0;
		res_l      = '0;
		res_t      = '0;
		res_r      = '0;
		res_b      = '0;
		unique case (cmd.kind)
			RES_CLEAR: ;
			RES_BAD:    res_status = STAT_BAD_SIZE;
			RES_NOROOM: res_status = STAT_NO_ROOM;
			RES_FIT: begin
				wr_en    = cmd.load_res;
				wr_x     = COORD_BITS'(sum_xw);
				res_page = PAGE_NUM_W'(idx_q);
				res_l    = FIELD_W'(x_e);
				res_t    = FIELD_W'(y_e);
				res_r    = FIELD_W'(sum_xw);
				res_b    = FIELD_W'(ny);
			end
			RES_SHELF: begin
				wr_en    = cmd.load_res;
				wr_x     = COORD_BITS'(w_e);
				wr_y     = COORD_BITS'(ny);
				wr_h     = COORD_BITS'(h_e);
				res_page = PAGE_NUM_W'(idx_q);
				res_t    = FIELD_W'(ny);
				res_r    = w_q;
				res_b    = FIELD_W'(sum_nyh);
			end
			RES_OPEN: begin
				wr_en    = cmd.load_res;
				wr_addr  = IW'(pages_open_q);
				wr_x     = COORD_BITS'(w_e);
				wr_y     = '0;
				wr_h     = COORD_BITS'(h_e);
				res_page = PAGE_NUM_W'(pages_open_q);
				res_r    = w_q;
				res_b    = h_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			status      <= res_status;
			page_number <= res_page;
			left        <= res_l;
			top         <= res_t;
			right       <= res_r;
			bottom      <= res_b;
		end
	end

`ifndef NO_ASSERTIONS
	a_pages_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res && cmd.kind == RES_OPEN |-> pages_open_q < PW'(MAX_PAGES))
		else $error("page opened beyond capacity");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> 8'(idx_q) < 8'(pages_open_q))
		else $error("walk index ran past open pages");
`endif

endmodule
`default_nettype wire

FILE: src/shelf_pack_page_allocator.sv
// Input transfer to out_valid: clear or bad size is reported from the check;
// else the open pages are walked in order until a fit or a new shelf; after all
// open pages, or with none open, a new page is opened or no room is reported.
// Throughput: one item at a time; the next input transfer is taken the cycle after
// the result is registered, while that result may still wait on out_stall.
// Reset (arst_n low, async): no pages open, page_size 512, page_limit 16.
`default_nettype none
module shelf_pack_page_allocator import spa_pkg::*; #(
	parameter int MAX_PAGES  = 16,
	parameter int COORD_BITS = 13
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_write,
	input  wire logic [0:0]            cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// request channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  mode,
	input  wire logic [FIELD_W-1:0]    cell_width,
	input  wire logic [FIELD_W-1:0]    cell_height,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [PAGE_NUM_W-1:0]      page_number,
	output logic [FIELD_W-1:0]         left,
	output logic [FIELD_W-1:0]         top,
	output logic [FIELD_W-1:0]         right,
	output logic [FIELD_W-1:0]         bottom
);

	// Controller sequences one request: capture, size/clear check, page walk,
	// then open a new page or report no room. Datapath holds the config,
	// the page count, the per-page shelf store and the result register.
	ctrl_cmd_t  cmd;
	dp_status_t st;

	spa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	spa_datapath #(
		.MAX_PAGES  (MAX_PAGES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.cell_width  (cell_width),
		.cell_height (cell_height),
		.cmd         (cmd),
		.st          (st),
		.status      (status),
		.page_number (page_number),
		.left        (left),
		.top         (top),
		.right       (right),
		.bottom      (bottom)
	);

endmodule
`default_nettype wire
